/* rtl/core/bsr_pkg.sv */
// Package for the BMP byte stream to RGB565 converter.
// Holds header offsets, screen constants and pixel depth codes.
// No dependencies.
package bsr_pkg;

   // Header layout
   localparam logic [5:0] HEADER_BYTES  = 6'd54;
   localparam logic [5:0] HEADER_LAST   = 6'd53;
   localparam logic [5:0] OFS_WIDTH     = 6'd18;
   localparam logic [5:0] OFS_HEIGHT_LO = 6'd22;
   localparam logic [5:0] OFS_HEIGHT_HI = 6'd23;
   localparam logic [5:0] OFS_DEPTH     = 6'd28;

   // Target screen: centering applies below SCREEN_LIMIT columns
   localparam logic [7:0] SCREEN_WIDTH  = 8'd240;
   localparam logic [7:0] SCREEN_LIMIT  = SCREEN_WIDTH - 8'd1;

   // Bytes per pixel codes
   localparam logic [1:0] BPP_NONE = 2'd0;
   localparam logic [1:0] BPP_16   = 2'd2;
   localparam logic [1:0] BPP_24   = 2'd3;

   // Color field masks
   localparam logic [15:0] MASK_GREEN = 16'h07e0;
   localparam logic [15:0] MASK_RED   = 16'hf800;

   // Map a depth header byte (bits per pixel) to a bytes per pixel code
   function automatic logic [1:0] depth_code(input logic [7:0] depth_byte);
      logic [4:0] bytes;
      bytes = depth_byte[7:3];
      if (bytes == 5'd2) begin
         depth_code = BPP_16;
      end else if (bytes == 5'd3) begin
         depth_code = BPP_24;
      end else begin
         depth_code = BPP_NONE;
      end
   endfunction

endpackage

/* rtl/core/bmp_stream_to_rgb565_top.sv */
// Top level of the BMP byte stream to RGB565 converter.
// Parses the 54-byte header, then packs pixels and counts columns and rows.
// Depends on bsr_pkg and bsr_pixel_pack.
// Path: an accepted byte goes through the input register, then the output register,
// where its result, if any, is held until rsp_tready takes it.
// Throughput: one byte per cycle while no result waits on rsp_tready; a waiting result
// stalls the input register, and the next byte is still taken once that result moves.
// Reset: synchronous; resets all control state, the block stays idle until a
// byte arrives with the start-of-file flag.
module bmp_stream_to_rgb565_top
   import bsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] file_byte
   input  logic        req_tuser,   // [0] start_of_file
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] pixel_rgb565, [23:16] column,
                                    // [31:24] screen_column, [47:32] row
   output logic        rsp_tlast,   // last_pixel
   output logic        rsp_tuser    // [0] header_error
);

   // input register
   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;

   // parser state
   logic [5:0]  offset_ff, offset_in;
   logic [7:0]  width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [1:0]  bpp_ff, bpp_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic        done_ff, done_in;

   // output register
   logic        out_vld_ff, out_vld_in;
   logic [47:0] out_data_ff;
   logic        out_last_ff;
   logic        out_err_ff;

   // state as seen by the current item (restart zeroes it)
   logic [5:0]  eff_offset;
   logic [7:0]  eff_width;
   logic [15:0] eff_height;
   logic [1:0]  eff_bpp;
   logic [1:0]  eff_phase;
   logic [15:0] eff_acc;
   logic [7:0]  eff_col;
   logic [15:0] eff_row;
   logic        eff_done;

   logic        req_fire;
   logic        proc_fire;
   logic [15:0] acc_packed;
   logic [1:0]  phase_inc;
   logic [7:0]  col_inc;
   logic [15:0] row_inc;
   logic [8:0]  center_diff;
   logic [7:0]  center_ofs;

   logic        res_vld;
   logic [47:0] res_data;
   logic        res_last;
   logic        res_err;

   // handshakes
   assign proc_fire  = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || proc_fire;
   assign req_fire   = req_tvalid && req_tready;

   // apply restart to the state before use
   assign eff_offset = in_start_ff ? 6'd0  : offset_ff;
   assign eff_width  = in_start_ff ? 8'd0  : width_ff;
   assign eff_height = in_start_ff ? 16'd0 : height_ff;
   assign eff_bpp    = in_start_ff ? BPP_NONE : bpp_ff;
   assign eff_phase  = in_start_ff ? 2'd0  : phase_ff;
   assign eff_acc    = in_start_ff ? 16'd0 : acc_ff;
   assign eff_col    = in_start_ff ? 8'd0  : col_ff;
   assign eff_row    = in_start_ff ? 16'd0 : row_ff;
   assign eff_done   = in_start_ff ? 1'b0  : done_ff;

   bsr_pixel_pack u_pack (
      .bytes_per_pixel (eff_bpp),
      .byte_phase      (eff_phase),
      .acc             (eff_acc),
      .file_byte       (in_byte_ff),
      .acc_next        (acc_packed)
   );

   assign phase_inc = eff_phase + 2'd1;
   assign col_inc   = eff_col + 8'd1;
   assign row_inc   = eff_row + 16'd1;

   // centering offset for narrow images
   assign center_diff = {1'b0, SCREEN_WIDTH} - {1'b0, eff_width};
   assign center_ofs  = (eff_width < SCREEN_LIMIT) ? center_diff[8:1] : 8'd0;

   // next state and result
   always_comb begin
      offset_in = offset_ff;
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      done_in   = done_ff;
      res_vld   = 1'b0;
      res_data  = 48'd0;
      res_last  = 1'b0;
      res_err   = 1'b0;

      if (proc_fire) begin
         offset_in = eff_offset;
         width_in  = eff_width;
         height_in = eff_height;
         bpp_in    = eff_bpp;
         phase_in  = eff_phase;
         acc_in    = eff_acc;
         col_in    = eff_col;
         row_in    = eff_row;
         done_in   = eff_done;

         if (!eff_done) begin
            if (eff_offset != HEADER_BYTES) begin
               // capture header fields
               if (eff_offset == OFS_WIDTH) begin
                  width_in = in_byte_ff;
               end else if (eff_offset == OFS_HEIGHT_LO) begin
                  height_in = {eff_height[15:8], in_byte_ff};
               end else if (eff_offset == OFS_HEIGHT_HI) begin
                  height_in = {in_byte_ff, eff_height[7:0]};
               end else if (eff_offset == OFS_DEPTH) begin
                  bpp_in = depth_code(in_byte_ff);
               end
               offset_in = eff_offset + 6'd1;
               // check the header on its final byte
               if (eff_offset == HEADER_LAST) begin
                  if (eff_bpp == BPP_NONE || eff_width == 8'd0 || eff_height == 16'd0) begin
                     done_in = 1'b1;
                     res_vld = 1'b1;
                     res_err = 1'b1;
                  end
               end
            end else begin
               // pixel data
               acc_in   = acc_packed;
               phase_in = phase_inc;
               if (phase_inc == eff_bpp) begin
                  res_vld  = 1'b1;
                  res_data = {eff_row, eff_col + center_ofs, eff_col, acc_packed};
                  phase_in = 2'd0;
                  acc_in   = 16'd0;
                  col_in   = col_inc;
                  if (col_inc == eff_width) begin
                     col_in = 8'd0;
                     row_in = row_inc;
                     if (row_inc == eff_height) begin
                        res_last = 1'b1;
                        done_in  = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   // advance or drop the input register
   always_comb begin
      if (req_fire) begin
         in_vld_in = 1'b1;
      end else if (proc_fire) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   // hold a result until taken
   always_comb begin
      if (proc_fire && res_vld) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         offset_ff  <= 6'd0;
         width_ff   <= 8'd0;
         height_ff  <= 16'd0;
         bpp_ff     <= BPP_NONE;
         phase_ff   <= 2'd0;
         acc_ff     <= 16'd0;
         col_ff     <= 8'd0;
         row_ff     <= 16'd0;
         done_ff    <= 1'b1;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         offset_ff  <= offset_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         bpp_ff     <= bpp_in;
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         done_ff    <= done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (proc_fire && res_vld) begin
         out_data_ff <= res_data;
         out_last_ff <= res_last;
         out_err_ff  <= res_err;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

/* rtl/core/bsr_pixel_pack.sv */
// Pixel packer: folds one file byte into the partial RGB565 word.
// Handles 16-bit 1-5-5-5 and 24-bit BGR pixels. Uses bsr_pkg.
module bsr_pixel_pack
   import bsr_pkg::*;
(
   input  logic [1:0]  bytes_per_pixel,
   input  logic [1:0]  byte_phase,
   input  logic [15:0] acc,
   input  logic [7:0]  file_byte,
   output logic [15:0] acc_next
);

   logic [15:0] byte_wide;

   assign byte_wide = {8'd0, file_byte};

   // Merge the byte into the accumulator by depth and phase
   always_comb begin
      if (bytes_per_pixel == BPP_16) begin
         if (byte_phase == 2'd0) begin
            // low byte: blue stays, low green bits move up by one
            acc_next = {7'd0, file_byte[7:5], 1'b0, file_byte[4:0]};
         end else begin
            acc_next = acc + (byte_wide << 9);
         end
      end else begin
         case (byte_phase)
            2'd0:    acc_next = {11'd0, file_byte[7:3]};
            2'd1:    acc_next = acc + ((byte_wide << 3) & MASK_GREEN);
            default: acc_next = acc + ((byte_wide << 8) & MASK_RED);
         endcase
      end
   end

endmodule

/* verif/bmp_stream_to_rgb565_top_tb.sv */
// Testbench for bmp_stream_to_rgb565_top: streams BMP files one byte per item
// and checks every result against a predictor of the header parse and pixel packing.
// Depends on bsr_pkg and the converter RTL.
module bmp_stream_to_rgb565_top_tb
   import bsr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Depth byte values as found in a BMP header (bits per pixel)
   localparam logic [7:0] DEPTH_16 = 8'd16;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 150;
   localparam int RANDOM_PIXELS  = 15;
   localparam int MAX_PRINTS     = 200;

   typedef struct packed {
      logic [15:0] pixel;
      logic [7:0]  column;
      logic [7:0]  screen_column;
      logic [15:0] row;
      logic        last;
      logic        header_error;
   } pixel_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] file_byte
   logic        req_tuser  = 1'b0;   // [0] start_of_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // [15:0] pixel, [23:16] column,
                                     // [31:24] screen_column, [47:32] row
   logic        rsp_tlast;           // last_pixel
   logic        rsp_tuser;           // [0] header_error

   // Flow control modes: calm means no idling on that side
   bit send_calm = 1'b0;
   bit rsp_calm  = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;
   int error_count = 0;
   int live_bytes = 0;
   int pixels_predicted = 0;

   pixel_result_type expected_pixels[$];

   // Predictor state
   logic [5:0]  hdr_pos;
   logic [7:0]  img_width;
   logic [15:0] img_height;
   logic [1:0]  pix_bytes;
   logic [1:0]  phase;
   logic [15:0] accum;
   logic [7:0]  col_cnt;
   logic [15:0] row_cnt;
   logic        idle;

   bmp_stream_to_rgb565_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count one failure and print a line for it
   task automatic report_error(input string what, input logic [15:0] got_val,
                               input logic [15:0] want_val);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("%0t: %s: got %h, expected %h", $time, what, got_val, want_val);
      end
   endtask

   // Most gaps short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end else if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic void clear_model(input logic go_idle);
      hdr_pos    = '0;
      img_width  = '0;
      img_height = '0;
      pix_bytes  = BPP_NONE;
      phase      = '0;
      accum      = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      idle       = go_idle;
   endfunction

   // Predict the effect of one file byte; return 1 unless the byte is ignored
   function automatic bit convert_byte(input logic [7:0] value, input logic sof);
      pixel_result_type res;
      logic [7:0]       offset;
      res = '0;
      if (sof) begin
         clear_model(1'b0);
      end
      if (idle) begin
         return 1'b0;
      end

      // Header: pick out width, height and depth
      if (hdr_pos < HEADER_BYTES) begin
         if (hdr_pos == OFS_WIDTH) begin
            img_width = value;
         end else if (hdr_pos == OFS_HEIGHT_LO) begin
            img_height[7:0] = value;
         end else if (hdr_pos == OFS_HEIGHT_HI) begin
            img_height[15:8] = value;
         end else if (hdr_pos == OFS_DEPTH) begin
            if (value[7:3] == 5'd2) begin
               pix_bytes = BPP_16;
            end else if (value[7:3] == 5'd3) begin
               pix_bytes = BPP_24;
            end else begin
               pix_bytes = BPP_NONE;
            end
         end
         if (hdr_pos == HEADER_LAST) begin
            hdr_pos = HEADER_BYTES;
            if (pix_bytes == BPP_NONE || img_width == 8'd0 || img_height == 16'd0) begin
               idle = 1'b1;
               res.header_error = 1'b1;
               expected_pixels.push_back(res);
               pixels_predicted++;
            end
         end else begin
            hdr_pos = hdr_pos + 6'd1;
         end
         return 1'b1;
      end

      // Pixel bytes: 1-5-5-5 repack or BGR truncation
      if (pix_bytes == BPP_16) begin
         if (phase == 2'd0) begin
            accum = {7'd0, value[7:5], 1'b0, value[4:0]};
         end else begin
            accum = accum + {value[6:0], 9'd0};
         end
      end else begin
         if (phase == 2'd0) begin
            accum = {11'd0, value[7:3]};
         end else if (phase == 2'd1) begin
            accum = accum + {5'd0, value[7:2], 5'd0};
         end else begin
            accum = accum + {value[7:3], 11'd0};
         end
      end
      phase = phase + 2'd1;
      if (phase != pix_bytes) begin
         return 1'b1;
      end

      // Pixel complete: emit and advance column and row
      offset = (img_width < SCREEN_LIMIT) ? (SCREEN_WIDTH - img_width) >> 1 : 8'd0;
      res.pixel         = accum;
      res.column        = col_cnt;
      res.screen_column = col_cnt + offset;
      res.row           = row_cnt;
      phase   = '0;
      accum   = '0;
      col_cnt = col_cnt + 8'd1;
      if (col_cnt == img_width) begin
         col_cnt = '0;
         row_cnt = row_cnt + 16'd1;
         if (row_cnt == img_height) begin
            res.last = 1'b1;
            idle     = 1'b1;
         end
      end
      expected_pixels.push_back(res);
      pixels_predicted++;
      return 1'b1;
   endfunction

   // Send one item, idling first, and predict it once accepted
   task automatic send_byte(input logic [7:0] value, input logic sof);
      int gap;
      gap = send_calm ? 0 : pick_gap();
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (convert_byte(value, sof)) begin
         live_bytes++;
      end
   endtask

   // Send the first count header bytes; unused header bytes are random
   task automatic send_header(input logic [7:0] width, input logic [15:0] height,
                              input logic [7:0] depth, input int count);
      logic [7:0] value;
      for (int pos = 0; pos < count; pos++) begin
         value = 8'($urandom);
         if (pos == OFS_WIDTH) begin
            value = width;
         end else if (pos == OFS_HEIGHT_LO) begin
            value = height[7:0];
         end else if (pos == OFS_HEIGHT_HI) begin
            value = height[15:8];
         end else if (pos == OFS_DEPTH) begin
            value = depth;
         end
         send_byte(value, pos == 0);
      end
   endtask

   // Random data bytes, leaning toward all zeros and all ones
   task automatic send_data_bytes(input int count);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            send_byte(8'h00, 1'b0);
         end else if (roll == 1) begin
            send_byte(8'hff, 1'b0);
         end else begin
            send_byte(8'($urandom), 1'b0);
         end
      end
   endtask

   task automatic send_image(input logic [7:0] width, input logic [15:0] height,
                             input logic [7:0] depth);
      send_header(width, height, depth, int'(HEADER_BYTES));
      send_data_bytes(int'(width) * int'(height) * int'(depth[7:3]));
   endtask

   // Bytes before any start of file are dropped
   task automatic test_idle_after_reset();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h42, 1'b0);
   endtask

   // Unsupported depth and empty sizes give one error result, then idle
   task automatic test_bad_headers();
      send_header(8'd4, 16'd2, DEPTH_32, int'(HEADER_BYTES));
      send_header(8'd0, 16'd2, DEPTH_16, int'(HEADER_BYTES));
      send_header(8'd4, 16'd0, DEPTH_24, int'(HEADER_BYTES));
      send_byte(8'h5a, 1'b0);
   endtask

   // Extreme 16-bit pixels, then bytes after the last pixel
   task automatic test_16bit_pixels();
      logic [7:0] data [12] = '{8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'h7f,
                                8'h00, 8'h80, 8'h1f, 8'h00, 8'he0, 8'h03};
      send_header(8'd3, 16'd2, DEPTH_16, int'(HEADER_BYTES));
      foreach (data[i]) send_byte(data[i], 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   // Extreme 24-bit pixels, including low bits that get truncated
   task automatic test_24bit_pixels();
      logic [7:0] data [12] = '{8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff,
                                8'hf8, 8'h00, 8'h00, 8'h07, 8'h03, 8'h07};
      send_header(8'd2, 16'd2, DEPTH_24, int'(HEADER_BYTES));
      foreach (data[i]) send_byte(data[i], 1'b0);
   endtask

   // Start of file inside the header; the next test restarts on the last header byte
   task automatic test_restart();
      send_header(8'd5, 16'd3, DEPTH_24, 10);
      send_header(8'd3, 16'd1, DEPTH_16, int'(HEADER_LAST));
   endtask

   // Widths around the centering limit; each image is cut mid pixel by the next file
   task automatic test_centering();
      send_header(8'd238, 16'd1, DEPTH_16, int'(HEADER_BYTES));
      send_data_bytes(3);
      send_header(8'd239, 16'd1, DEPTH_24, int'(HEADER_BYTES));
      send_data_bytes(4);
   endtask

   // Height with a zero low byte passes the size check on its high byte
   task automatic test_tall_image();
      send_header(8'd1, 16'h0100, DEPTH_16, int'(HEADER_BYTES));
      send_data_bytes(8);
   endtask

   // Mostly well-formed files with random content, plus broken files and noise
   task automatic test_random_files();
      int         kind;
      int         total;
      int         pixels_start;
      logic [7:0] width;
      logic [15:0] height;
      logic [7:0] depth;
      live_bytes   = 0;
      pixels_start = pixels_predicted;
      while (live_bytes < RANDOM_ITEMS || pixels_predicted - pixels_start < RANDOM_PIXELS) begin
         send_calm = ($urandom_range(0, 4) == 0);
         rsp_calm  = ($urandom_range(0, 4) == 0);
         kind   = $urandom_range(0, 99);
         depth  = {($urandom_range(0, 1) ? 5'd3 : 5'd2), 3'($urandom)};
         width  = 8'($urandom_range(1, 6));
         height = 16'($urandom_range(1, 3));
         if (kind < 5) begin
            width  = 8'($urandom_range(200, 255));
            height = 16'd1;
         end
         if (kind < 75) begin
            send_image(width, height, depth);
            if ($urandom_range(0, 3) == 0) begin
               send_data_bytes($urandom_range(1, 4));
            end
         end else if (kind < 87) begin
            // cut off anywhere, any size
            width  = 8'($urandom);
            height = 16'($urandom);
            total  = $urandom_range(1, 120);
            send_header(width, height, depth,
                        (total < int'(HEADER_BYTES)) ? total : int'(HEADER_BYTES));
            if (total > int'(HEADER_BYTES)) begin
               send_data_bytes(total - int'(HEADER_BYTES));
            end
         end else if (kind < 95) begin
            case ($urandom_range(0, 2))
               0: begin
                  do depth = 8'($urandom); while (depth[7:3] == 5'd2 || depth[7:3] == 5'd3);
               end
               1: width = 8'd0;
               default: height = 16'd0;
            endcase
            send_header(width, height, depth, int'(HEADER_BYTES));
         end else begin
            send_data_bytes($urandom_range(1, 8));
         end
      end
      send_calm = 1'b0;
      rsp_calm  = 1'b0;
   endtask

   // Stall the result side at random
   always @(posedge clock) begin
      if (stall_left == 0 && !rsp_calm) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result with the oldest expected pixel
   always @(posedge clock) begin : check_results
      pixel_result_type got;
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pixel         = rsp_tdata[15:0];
         got.column        = rsp_tdata[23:16];
         got.screen_column = rsp_tdata[31:24];
         got.row           = rsp_tdata[47:32];
         got.last          = rsp_tlast;
         got.header_error  = rsp_tuser;
         if (expected_pixels.size() == 0) begin
            report_error("result with nothing expected", got.pixel, 16'd0);
         end else begin
            want = expected_pixels.pop_front();
            if (got.pixel !== want.pixel) begin
               report_error("pixel_rgb565", got.pixel, want.pixel);
            end
            if (got.column !== want.column) begin
               report_error("column", 16'(got.column), 16'(want.column));
            end
            if (got.screen_column !== want.screen_column) begin
               report_error("screen_column", 16'(got.screen_column),
                            16'(want.screen_column));
            end
            if (got.row !== want.row) begin
               report_error("row", got.row, want.row);
            end
            if (got.last !== want.last) begin
               report_error("last_pixel", 16'(got.last), 16'(want.last));
            end
            if (got.header_error !== want.header_error) begin
               report_error("header_error", 16'(got.header_error),
                            16'(want.header_error));
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_model(1'b1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_idle_after_reset();
      test_bad_headers();
      test_16bit_pixels();
      test_24bit_pixels();
      test_restart();
      test_centering();
      test_tall_image();
      test_random_files();

      // Drain outstanding pixels, then watch for strays
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (expected_pixels.size() != 0) begin
         report_error("pixel never produced", 16'd0, expected_pixels.pop_front().pixel);
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
